>>> rtl/iss_pkg.sv
// shared types and constants of the insertion sorter
package iss_pkg;

   localparam int ISS_CAPACITY  = 8;
   localparam int ISS_KEY_WIDTH = 32;

   // one slot of the sorted chain
   typedef struct packed {
      logic                            valid;
      logic signed [ISS_KEY_WIDTH-1:0] key;
   } iss_slot_type;

   // per-cycle command shared by every cell
   typedef struct packed {
      logic insert;
      logic drain;
   } iss_ctl_type;

   // controller states
   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } iss_state_type;

endpackage

>>> rtl/iss_req_if.sv
// key channel: valid, ready and one key with its end-of-set flag
interface iss_req_if
   import iss_pkg::*;
();
   logic                            valid;
   logic                            ready;
   logic signed [ISS_KEY_WIDTH-1:0] key_value;
   logic                            last;

   modport source (output valid, output key_value, output last, input ready);
   modport sink   (input valid, input key_value, input last, output ready);
endinterface

>>> rtl/iss_rsp_if.sv
// result channel: valid, ready and one sorted key with its flags
interface iss_rsp_if
   import iss_pkg::*;
();
   logic                            valid;
   logic                            ready;
   logic signed [ISS_KEY_WIDTH-1:0] sorted_value;
   logic                            last_res;
   logic                            dropped;

   modport source (output valid, output sorted_value, output last_res, output dropped,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_res, input dropped,
                   output ready);
endinterface

>>> rtl/iss_cell.sv
// one cell of the sorting chain: holds a key and trades with its neighbours
module iss_cell
   import iss_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  iss_ctl_type                     ctl,
   input  logic signed [ISS_KEY_WIDTH-1:0] new_key,
   input  iss_slot_type                    lower_slot,
   input  logic                            lower_gt,
   input  iss_slot_type                    upper_slot,
   output iss_slot_type                    slot,
   output logic                            gt
);

   logic                            valid_ff;
   logic                            valid_in;
   logic signed [ISS_KEY_WIDTH-1:0] key_ff;
   logic signed [ISS_KEY_WIDTH-1:0] key_in;

   // an empty cell counts as greater than any key
   assign gt = !valid_ff || ($signed(key_ff) > $signed(new_key));

   // insert shifts greater keys up; drain shifts everything down
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (ctl.insert && gt) begin
         if (lower_gt) begin
            valid_in = lower_slot.valid;
            key_in   = lower_slot.key;
         end else begin
            valid_in = 1'b1;
            key_in   = new_key;
         end
      end else if (ctl.drain) begin
         valid_in = upper_slot.valid;
         key_in   = upper_slot.key;
      end
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // key storage
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign slot.valid = valid_ff;
   assign slot.key   = key_ff;

endmodule

>>> rtl/insertion_sort_ascending_top.sv
// top level of the ascending insertion sorter
//
//   channel    | dir | payload                            | handshake
//   req_chan   | in  | key_value[31:0] signed, last       | valid / ready
//   rsp_chan   | out | sorted_value[31:0], last_res, drop | valid / ready
//
// all cells compare against each key in parallel and the greater ones
// step up one place in the same edge that accepts the key.
// the key marked last closes the set; results then leave one a cycle from
// the bottom cell while rsp_ready stays high. keys are refused while a set
// drains.
// synchronous reset empties the chain at once; rsp_ready low holds the
// current result and the chain.
module insertion_sort_ascending_top
   import iss_pkg::*;
#(
   parameter int CAPACITY = ISS_CAPACITY
)
(
   input  logic     clock,
   input  logic     reset,
   iss_req_if.sink   req_chan,
   iss_rsp_if.source rsp_chan
);

   iss_state_type state_ff;
   iss_state_type state_in;
   logic          overflow_ff;
   logic          overflow_in;
   iss_ctl_type   ctl;
   logic          req_fire;
   logic          rsp_fire;
   logic          full;

   iss_slot_type  slot_q [CAPACITY];
   logic          gt_q   [CAPACITY];

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      iss_slot_type lower_slot;
      logic         lower_gt;
      iss_slot_type upper_slot;

      if (i == 0) begin : g_bottom
         assign lower_slot = '0;
         assign lower_gt   = 1'b0;
      end else begin : g_mid_lo
         assign lower_slot = slot_q[i-1];
         assign lower_gt   = gt_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign upper_slot = '0;
      end else begin : g_mid_hi
         assign upper_slot = slot_q[i+1];
      end

      iss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_key    (req_chan.key_value),
         .lower_slot (lower_slot),
         .lower_gt   (lower_gt),
         .upper_slot (upper_slot),
         .slot       (slot_q[i]),
         .gt         (gt_q[i])
      );
   end

   // handshakes
   assign full              = slot_q[CAPACITY-1].valid;
   assign req_chan.ready    = (state_ff == ST_LOAD);
   assign req_fire          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid    = (state_ff == ST_DRAIN) && slot_q[0].valid;
   assign rsp_fire          = rsp_chan.valid && rsp_chan.ready;

   // result payload: key from the bottom cell, last when the cell above is empty, drop flag from the controller
   assign rsp_chan.sorted_value = slot_q[0].key;
   assign rsp_chan.last_res     = !slot_q[1].valid;
   assign rsp_chan.dropped      = overflow_ff;

   // cell commands
   assign ctl.insert = req_fire && !full;
   assign ctl.drain  = rsp_fire;

   // load / drain sequencing and drop flag
   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && full) begin
               overflow_in = 1'b1;
            end
            if (req_fire && req_chan.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire && rsp_chan.last_res) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in    = ST_LOAD;
            overflow_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

>>> rtl/iss_checker.sv
// port-level checks of the insertion sorter and their binding
module iss_checker
   import iss_pkg::*;
(
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_last,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [ISS_KEY_WIDTH-1:0] rsp_sorted_value,
   input logic                            rsp_last_res,
   input logic                            rsp_dropped
);

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value)
                                 && $stable(rsp_last_res) && $stable(rsp_dropped))
      else $error("stalled result changed");

   // no key transaction while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && rsp_valid))
      else $error("key taken while draining");

   // closing a set always produces a result
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last |=> rsp_valid)
      else $error("closed set produced no result");

   // the run continues until its last result
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last_res |=> rsp_valid && $stable(rsp_dropped))
      else $error("sorted run broken early");

   // results come in ascending order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last_res |=> $signed(rsp_sorted_value) >= $signed($past(rsp_sorted_value)))
      else $error("results out of order");

endmodule

bind insertion_sort_ascending_top iss_checker u_iss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_last         (req_chan.last),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_sorted_value (rsp_chan.sorted_value),
   .rsp_last_res     (rsp_chan.last_res),
   .rsp_dropped      (rsp_chan.dropped)
);

>>> verif/insertion_sort_ascending_top_test.sv
// self-checking testbench for the ascending insertion sorter
`timescale 1ns / 1ps

module insertion_sort_ascending_top_test;
   import iss_pkg::*;

   typedef logic signed [ISS_KEY_WIDTH-1:0] sort_key_type;

   // one sorted key as it should leave the block
   typedef struct {
      sort_key_type value;
      bit           last_res;
      bit           dropped;
   } sorted_key_type;

   // receiver stall patterns
   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_EVERY_THIRD,
      RX_RARE_STALL
   } rx_mode_type;

   localparam sort_key_type KEY_MIN = {1'b1, {(ISS_KEY_WIDTH-1){1'b0}}};
   localparam sort_key_type KEY_MAX = {1'b0, {(ISS_KEY_WIDTH-1){1'b1}}};
   localparam int           TARGET_KEYS = 420;

   // sorted-store predictor and queue of sorted keys still owed by the block
   class sort_scoreboard;
      sort_key_type   sorted_store[$];
      bit             overflow_seen;
      sorted_key_type owed_keys[$];
      int             errors;

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // insert an accepted key; a closing key releases the whole set
      function void note_key(input sort_key_type key, input bit is_last);
         int             pos;
         sorted_key_type item;
         if (sorted_store.size() < ISS_CAPACITY) begin
            pos = sorted_store.size();
            // equal keys stay put so arrival order survives
            while (pos > 0 && sorted_store[pos-1] > key)
               pos--;
            sorted_store.insert(pos, key);
         end else begin
            overflow_seen = 1'b1;
         end
         if (is_last) begin
            foreach (sorted_store[k]) begin
               item.value    = sorted_store[k];
               item.last_res = (k == sorted_store.size() - 1);
               item.dropped  = overflow_seen;
               owed_keys.push_back(item);
            end
            sorted_store.delete();
            overflow_seen = 1'b0;
         end
      endfunction

      task check_result(input sort_key_type value, input logic last_res, input logic dropped);
         sorted_key_type want;
         if (owed_keys.size() == 0) begin
            report($sformatf("unexpected result %0d", value));
         end else begin
            want = owed_keys.pop_front();
            if (value !== want.value)
               report($sformatf("sorted_value %0d, expected %0d", value, want.value));
            if (last_res !== want.last_res)
               report($sformatf("last_res %b, expected %b on key %0d",
                                last_res, want.last_res, want.value));
            if (dropped !== want.dropped)
               report($sformatf("dropped %b, expected %b on key %0d",
                                dropped, want.dropped, want.value));
         end
      endtask

      function int pending();
         return owed_keys.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   iss_req_if req_chan ();
   iss_rsp_if rsp_chan ();

   insertion_sort_ascending_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sort_scoreboard board = new();
   int             keys_sent;
   int             burst_left;

   // clock generation
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            board.note_key(req_chan.key_value, req_chan.last);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_result(rsp_chan.sorted_value, rsp_chan.last_res, rsp_chan.dropped);
      end
   end

   // receiver back-pressure, with the stall pattern redrawn at random during the run
   initial begin
      int          phase;
      rx_mode_type rx_mode;
      phase   = 0;
      rx_mode = RX_ALWAYS;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (phase % 50 == 0)
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_ALWAYS:      rsp_chan.ready <= 1'b1;
            RX_COIN:        rsp_chan.ready <= 1'($urandom_range(0, 1));
            RX_EVERY_THIRD: rsp_chan.ready <= (phase % 3 == 0);
            default:        rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         endcase
         phase++;
      end
   end

   // present one key, idling at burst boundaries; returns at the next falling edge
   task automatic send_key(input sort_key_type key, input bit is_last);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.key_value <= key;
      req_chan.last      <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      keys_sent++;
   endtask

   task automatic send_set(input sort_key_type keys[$]);
      foreach (keys[k])
         send_key(keys[k], k == keys.size() - 1);
   endtask

   // hold the sender off until every owed key has come back
   task automatic drain_wait();
      req_chan.valid <= 1'b0;
      while (board.pending() != 0)
         @(negedge clock);
   endtask

   function automatic sort_key_type random_key();
      case ($urandom_range(0, 5))
         0:       return sort_key_type'($urandom_range(0, 10)) - 5;
         1: begin
            case ($urandom_range(0, 3))
               0:       return KEY_MIN;
               1:       return KEY_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return sort_key_type'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      sort_key_type key_set[$];
      int           set_len;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.key_value <= '0;
      req_chan.last      <= 1'b0;
      keys_sent          = 0;
      burst_left         = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-key set at the most negative key
      send_set('{KEY_MIN});
      // extremes with a repeated key closing the set
      send_set('{KEY_MAX, KEY_MIN, sort_key_type'(0), sort_key_type'(-1), sort_key_type'(0)});
      // exactly full, already ascending
      send_set('{KEY_MIN, sort_key_type'(-100), sort_key_type'(-1), sort_key_type'(0),
                 sort_key_type'(1), sort_key_type'(100), KEY_MAX - 1, KEY_MAX});
      // descending so every key shifts, closing key dropped on a full store
      send_set('{sort_key_type'(9), sort_key_type'(8), sort_key_type'(7), sort_key_type'(6),
                 sort_key_type'(5), sort_key_type'(4), sort_key_type'(3), sort_key_type'(2),
                 sort_key_type'(1)});
      drain_wait();

      // random sets, mostly within capacity, some overflowing
      while (keys_sent < TARGET_KEYS) begin
         if ($urandom_range(0, 4) == 0)
            set_len = $urandom_range(ISS_CAPACITY + 1, ISS_CAPACITY + 4);
         else
            set_len = $urandom_range(1, ISS_CAPACITY);
         key_set.delete();
         repeat (set_len) key_set.push_back(random_key());
         send_set(key_set);
         if ($urandom_range(0, 7) == 0)
            drain_wait();
      end

      // wind down
      req_chan.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (2 * ISS_CAPACITY + 10) @(posedge clock);
      if (board.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
